FILE: hdl/lbp_pkg.sv
// Shared types and constants for the 3x3 local binary pattern block.
package lbp_pkg;

   localparam int LBP_MAX_WIDTH   = 1024;
   localparam int LBP_PIX_W       = 8;
   localparam int LBP_LW_W        = 11;
   localparam int LBP_FH_W        = 12;
   localparam int LBP_FIFO_DEPTH  = 4;
   localparam int LBP_FIFO_CNT_W  = $clog2(LBP_FIFO_DEPTH + 1);

   localparam logic [LBP_LW_W-1:0] LBP_LW_RESET = 11'd640;
   localparam logic [LBP_FH_W-1:0] LBP_FH_RESET = 12'd480;

   // register indexes, selected by csr_paddr[2]
   localparam logic LBP_REG_LINE_WIDTH   = 1'b0;
   localparam logic LBP_REG_FRAME_HEIGHT = 1'b1;

   typedef logic [LBP_PIX_W-1:0] lbp_pix_type;

   // one window column: rows r-2, r-1, r
   typedef struct packed {
      lbp_pix_type upper;
      lbp_pix_type middle;
      lbp_pix_type lower;
   } lbp_col_type;

   // one result beat
   typedef struct packed {
      lbp_pix_type code;
      logic        last;
   } lbp_rsp_type;

endpackage

FILE: hdl/local_binary_pattern_3x3.sv
// Top level of the 3x3 local binary pattern block: counters, pipeline and CSRs.
//
// Pixels enter on the req_ stream in raster order, one beat per pixel, and an
// 8-bit pattern code leaves on the rsp_ stream for every interior pixel;
// border pixels give no beat. rsp_tlast marks the code of the last interior
// pixel of the frame. Frame geometry comes from two CSRs on the csr_ port:
// line_width at 0x0 and frame_height at 0x4; any write restarts the frame.
// The block takes one pixel per clock while req_tready is high. A code is on
// rsp_tvalid once the beat of the pixel below-right of its center is taken
// and has passed the line store read at the accept edge, the window shift
// and the enqueue into the result queue, in that order.
// The line stores are one dual-entry RAM indexed by column, read in the
// accept cycle and written back the cycle after; the window is nine bytes.
// A four-beat result queue sits on the output. When the receiver stalls,
// req_tready drops once the queue plus the items in flight would fill it,
// so no code is lost. Reset clears counters, window and queue and restores
// line_width 640 and frame_height 480; line store contents need no clear,
// since the first two rows of every frame refill them before any code.
module local_binary_pattern_3x3 #(
   parameter int MAX_WIDTH = lbp_pkg::LBP_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   // req: pixel beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   // rsp: code beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] lbp_code
   output logic        rsp_tlast,   // frame_last
   // csr
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lbp_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CMP_W = ($clog2(MAX_WIDTH + 1) > LBP_LW_W) ? $clog2(MAX_WIDTH + 1) : LBP_LW_W;
   localparam int OCC_W = LBP_FIFO_CNT_W + 1;

   // csr
   logic [LBP_LW_W-1:0] line_width_ff;
   logic [LBP_FH_W-1:0] frame_height_ff;
   logic                csr_wr;

   // counters
   logic [COL_W-1:0]    col_ff, col_in, w_last;
   logic [LBP_FH_W-1:0] row_ff, row_in, h_last;
   logic [CMP_W-1:0]    lw_ext;

   // pipeline
   logic                accept;
   logic                s1_v_ff, s1_emit_ff, s1_last_ff;
   lbp_pix_type         s1_px_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s2_v_ff, s2_emit_ff, s2_last_ff;
   lbp_pix_type         rd_upper, rd_middle, code;
   lbp_col_type         new_col;
   lbp_rsp_type         push_data, out_data;
   logic [LBP_FIFO_CNT_W-1:0] fifo_count;
   logic [OCC_W-1:0]    occupancy;

   // ---------------- CSR port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= LBP_LW_RESET;
         frame_height_ff <= LBP_FH_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            LBP_REG_LINE_WIDTH:   line_width_ff   <= csr_pwdata[LBP_LW_W-1:0];
            LBP_REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[LBP_FH_W-1:0];
            default:              line_width_ff   <= line_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         LBP_REG_LINE_WIDTH:   csr_prdata = {{(32-LBP_LW_W){1'b0}}, line_width_ff};
         LBP_REG_FRAME_HEIGHT: csr_prdata = {{(32-LBP_FH_W){1'b0}}, frame_height_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------- clamped geometry ----------------
   assign lw_ext = CMP_W'(line_width_ff);

   always_comb begin
      priority if (lw_ext < CMP_W'(3)) begin
         w_last = COL_W'(2);
      end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
         w_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last = COL_W'(lw_ext - CMP_W'(1));
      end
      if (frame_height_ff < LBP_FH_W'(3)) begin
         h_last = LBP_FH_W'(2);
      end else begin
         h_last = frame_height_ff - LBP_FH_W'(1);
      end
   end

   // ---------------- raster counters ----------------
   assign occupancy  = OCC_W'(fifo_count) + OCC_W'(s1_v_ff) + OCC_W'(s2_v_ff);
   assign req_tready = occupancy < OCC_W'(LBP_FIFO_DEPTH);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == w_last) begin
            col_in = '0;
            row_in = (row_ff == h_last) ? '0 : row_ff + LBP_FH_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- pipeline control ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff   <= req_tdata;
         s1_col_ff  <= col_ff;
         s1_emit_ff <= (row_ff >= LBP_FH_W'(2)) && (col_ff >= COL_W'(2));
         s1_last_ff <= (row_ff == h_last) && (col_ff == w_last);
      end
      if (s1_v_ff) begin
         s2_emit_ff <= s1_emit_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // read at accept, write back the shifted column in the cycle after
   lbp_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (col_ff),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle),
      .wr_en     (s1_v_ff),
      .wr_addr   (s1_col_ff),
      .wr_upper  (rd_middle),
      .wr_middle (s1_px_ff)
   );

   assign new_col = '{upper: rd_upper, middle: rd_middle, lower: s1_px_ff};

   lbp_window u_window (
      .clock    (clock),
      .reset    (reset),
      .shift_en (s1_v_ff),
      .new_col  (new_col),
      .code     (code)
   );

   assign push_data = '{code: code, last: s2_last_ff};

   lbp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_v_ff && s2_emit_ff),
      .push_data (push_data),
      .pop       (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_tdata = out_data.code;
   assign rsp_tlast = out_data.last;

   // ---------------- checks ----------------
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      accept && s1_v_ff |-> col_ff != s1_col_ff)
      else $error("line store read and write-back hit the same column");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= OCC_W'(LBP_FIFO_DEPTH))
      else $error("items in flight exceed result queue space");

   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |=> s2_v_ff)
      else $error("pipeline dropped a beat between window stages");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_wr |-> col_ff <= w_last)
      else $error("column counter beyond line width");

endmodule

FILE: hdl/lbp_line_store.sv
// Two line stores packed into one synchronous RAM with a registered read port.
module lbp_line_store #(
   parameter int MAX_WIDTH = lbp_pkg::LBP_MAX_WIDTH
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   output lbp_pkg::lbp_pix_type         rd_upper,
   output lbp_pkg::lbp_pix_type         rd_middle,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  lbp_pkg::lbp_pix_type         wr_upper,
   input  lbp_pkg::lbp_pix_type         wr_middle
);
   import lbp_pkg::*;

   logic [2*LBP_PIX_W-1:0] mem [MAX_WIDTH];
   logic [2*LBP_PIX_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_upper, wr_middle};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_upper  = rd_ff[2*LBP_PIX_W-1:LBP_PIX_W];
   assign rd_middle = rd_ff[LBP_PIX_W-1:0];

endmodule

FILE: hdl/lbp_window.sv
// 3x3 window shift register and the pattern compare against the center pixel.
module lbp_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift_en,
   input  lbp_pkg::lbp_col_type new_col,
   output lbp_pkg::lbp_pix_type code
);
   import lbp_pkg::*;

   lbp_col_type left_ff, center_ff, right_ff;
   lbp_pix_type c;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         center_ff <= '0;
         right_ff  <= '0;
      end else if (shift_en) begin
         left_ff   <= center_ff;
         center_ff <= right_ff;
         right_ff  <= new_col;
      end
   end

   // bit 7 top-left, clockwise, bit 0 left
   always_comb begin
      c       = center_ff.middle;
      code[7] = left_ff.upper    > c;
      code[6] = center_ff.upper  > c;
      code[5] = right_ff.upper   > c;
      code[4] = right_ff.middle  > c;
      code[3] = right_ff.lower   > c;
      code[2] = center_ff.lower  > c;
      code[1] = left_ff.lower    > c;
      code[0] = left_ff.middle   > c;
   end

endmodule

FILE: hdl/lbp_out_fifo.sv
// Small result queue that decouples the pipeline from a stalling receiver.
module lbp_out_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  lbp_pkg::lbp_rsp_type                push_data,
   input  logic                                pop,
   output logic                                out_valid,
   output lbp_pkg::lbp_rsp_type                out_data,
   output logic [lbp_pkg::LBP_FIFO_CNT_W-1:0]  count
);
   import lbp_pkg::*;

   localparam int PTR_W = $clog2(LBP_FIFO_DEPTH);

   lbp_rsp_type               slot_ff [LBP_FIFO_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, rd_ptr_ff;
   logic [LBP_FIFO_CNT_W-1:0] count_ff, count_in;
   logic                      do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + LBP_FIFO_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - LBP_FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |-> count_ff < LBP_FIFO_CNT_W'(LBP_FIFO_DEPTH))
      else $error("result queue overflow");

endmodule
